### src/kbpc_pkg.sv
// Package: shared constants, types and control structs of the pair cost block.
`timescale 1ns / 1ps
package kbpc_pkg;

    localparam int NODE_W     = 8;
    localparam int NODES      = 1 << NODE_W;
    localparam int MAX_EDGES  = 1024;
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int ECNT_W     = EDGE_AW + 1;
    localparam int WEIGHT_W   = 32;
    localparam int EDGE_W     = WEIGHT_W + 2 * NODE_W;
    localparam int CNT_W      = 17;
    localparam int TOK_MAX    = 511;
    localparam int COST_W     = 40;
    localparam int PROD_W     = WEIGHT_W + CNT_W;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_SRC  = 2'd1,
        OP_SNK  = 2'd2,
        OP_RUN  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_INS_CHK,
        S_INS_CMP,
        S_TOK_RD,
        S_TOK_UPD,
        S_RUN_EDGE,
        S_RUN_LAT,
        S_FIND_RD,
        S_FIND_CHK,
        S_MRG_RA,
        S_MRG_RB,
        S_MRG_SUM,
        S_MRG_MUL,
        S_MRG_ACC,
        S_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic set_drop;
        logic ins_rd;
        logic ins_shift;
        logic ins_new;
        logic tok_rd;
        logic tok_upd;
        logic edge_rd;
        logic edge_lat;
        logic find_step;
        logic set_ru;
        logic set_rv;
        logic cnt_rd_ru;
        logic cnt_rd_rv;
        logic sum;
        logic mul;
        logic acc;
        logic next_edge;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic edge_full;
        logic pos_zero;
        logic shift_gt;
        logic run_done;
        logic is_root;
        logic phase;
        logic same_root;
        logic clr_last;
    } sts_t;

endpackage

### src/kbpc_in_if.sv
// Interface: input item channel (load and run commands).
`timescale 1ns / 1ps
interface kbpc_in_if;
    import kbpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [NODE_W-1:0]   vertex_a;
    logic [NODE_W-1:0]   vertex_b;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, opcode, vertex_a, vertex_b, weight, input ready);
    modport sink   (input valid, opcode, vertex_a, vertex_b, weight, output ready);
endinterface

### src/kbpc_out_if.sv
// Interface: result item channel.
`timescale 1ns / 1ps
interface kbpc_out_if;
    import kbpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] total_cost;
    logic              overflow;

    modport source (output valid, total_cost, overflow, input ready);
    modport sink   (input valid, total_cost, overflow, output ready);
endinterface

### src/kbpc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module kbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### src/kbpc_ctrl.sv
// Controller: sequences loading, sorted insertion, union-find and clearing.
`timescale 1ns / 1ps
module kbpc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  kbpc_pkg::sts_t  sts,
    output kbpc_pkg::cmd_t  cmd
);
    import kbpc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_DISP;
            S_DISP:
            begin
                case (sts.op)
                    OP_EDGE: state_next = sts.edge_full ? S_IDLE : S_INS_CHK;
                    OP_SRC,
                    OP_SNK:  state_next = S_TOK_RD;
                    default: state_next = S_RUN_EDGE;
                endcase
            end
            S_INS_CHK:  state_next = sts.pos_zero ? S_IDLE : S_INS_CMP;
            S_INS_CMP:  state_next = sts.shift_gt ? S_INS_CHK : S_IDLE;
            S_TOK_RD:   state_next = S_TOK_UPD;
            S_TOK_UPD:  state_next = S_IDLE;
            S_RUN_EDGE: state_next = sts.run_done ? S_OUT : S_RUN_LAT;
            S_RUN_LAT:  state_next = S_FIND_RD;
            S_FIND_RD:  state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (!sts.is_root || !sts.phase)
                    state_next = S_FIND_RD;
                else if (sts.same_root)
                    state_next = S_RUN_EDGE;
                else
                    state_next = S_MRG_RA;
            end
            S_MRG_RA:   state_next = S_MRG_RB;
            S_MRG_RB:   state_next = S_MRG_SUM;
            S_MRG_SUM:  state_next = S_MRG_MUL;
            S_MRG_MUL:  state_next = S_MRG_ACC;
            S_MRG_ACC:  state_next = S_RUN_EDGE;
            S_OUT:      if (out_ready) state_next = S_CLEAR;
            default:    state_next = S_CLEAR;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_DISP:     cmd.set_drop = (sts.op == OP_EDGE) && sts.edge_full;
            S_INS_CHK:
            begin
                cmd.ins_new = sts.pos_zero;
                cmd.ins_rd  = !sts.pos_zero;
            end
            S_INS_CMP:
            begin
                cmd.ins_shift = sts.shift_gt;
                cmd.ins_new   = !sts.shift_gt;
            end
            S_TOK_RD:   cmd.tok_rd = 1'b1;
            S_TOK_UPD:  cmd.tok_upd = 1'b1;
            S_RUN_EDGE: cmd.edge_rd = !sts.run_done;
            S_RUN_LAT:  cmd.edge_lat = 1'b1;
            S_FIND_RD:  ;
            S_FIND_CHK:
            begin
                cmd.find_step = !sts.is_root;
                cmd.set_ru    = sts.is_root && !sts.phase;
                cmd.set_rv    = sts.is_root && sts.phase;
                cmd.next_edge = sts.is_root && sts.phase && sts.same_root;
            end
            S_MRG_RA:   cmd.cnt_rd_ru = 1'b1;
            S_MRG_RB:   cmd.cnt_rd_rv = 1'b1;
            S_MRG_SUM:  cmd.sum = 1'b1;
            S_MRG_MUL:  cmd.mul = 1'b1;
            S_MRG_ACC:
            begin
                cmd.acc       = 1'b1;
                cmd.next_edge = 1'b1;
            end
            S_OUT:      out_valid = 1'b1;
            default:    ;
        endcase
    end
endmodule

### src/kbpc_dp.sv
// Datapath: edge store, union-find links, token counters and cost accumulator.
`timescale 1ns / 1ps
module kbpc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kbpc_pkg::cmd_t                  cmd,
    output kbpc_pkg::sts_t                  sts,
    input  logic [1:0]                      opcode,
    input  logic [kbpc_pkg::NODE_W-1:0]     vertex_a,
    input  logic [kbpc_pkg::NODE_W-1:0]     vertex_b,
    input  logic [kbpc_pkg::WEIGHT_W-1:0]   weight,
    output logic [kbpc_pkg::COST_W-1:0]     total_cost,
    output logic                            overflow
);
    import kbpc_pkg::*;

    // Item and control registers
    op_t                 op_reg;
    logic [NODE_W-1:0]   a_reg, b_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [ECNT_W-1:0]   count_reg, pos_reg, i_reg;
    logic                drop_reg, phase_reg;
    logic [NODE_W-1:0]   clr_idx_reg;
    logic [COST_W-1:0]   total_reg;
    // Run working registers
    logic [NODE_W-1:0]   eu_reg, ev_reg, x_reg, ru_reg, rv_reg;
    logic [WEIGHT_W-1:0] ew_reg;
    logic [2*CNT_W-1:0]  ca_reg;
    logic [CNT_W-1:0]    s_reg, k_reg, m_reg;
    logic [PROD_W-1:0]   prod_reg;

    // RAM ports
    logic                edge_we;
    logic [EDGE_AW-1:0]  edge_wa, edge_ra;
    logic [EDGE_W-1:0]   edge_wd, edge_rd;
    logic                par_we;
    logic [NODE_W-1:0]   par_wa, par_wd, par_rd;
    logic                cnt_we;
    logic [NODE_W-1:0]   cnt_wa, cnt_ra;
    logic [2*CNT_W-1:0]  cnt_wd, cnt_rd;

    logic [ECNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]    tok_field;
    logic [CNT_W:0]      s_sum, k_sum;
    logic [COST_W+9:0]   acc_sum;

    kbpc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
        .rd_addr(edge_ra), .rd_data(edge_rd)
    );

    kbpc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_par_ram (
        .clk(clk), .we(par_we), .wr_addr(par_wa), .wr_data(par_wd),
        .rd_addr(x_reg), .rd_data(par_rd)
    );

    kbpc_ram #(.WIDTH(2 * CNT_W), .DEPTH(NODES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
        .rd_addr(cnt_ra), .rd_data(cnt_rd)
    );

    assign pos_m1    = pos_reg - ECNT_W'(1);
    // Token field picked by opcode: sources high half, sinks low half
    assign tok_field = (op_reg == OP_SRC) ? cnt_rd[2*CNT_W-1:CNT_W] : cnt_rd[CNT_W-1:0];
    assign s_sum     = {1'b0, ca_reg[2*CNT_W-1:CNT_W]} + {1'b0, cnt_rd[2*CNT_W-1:CNT_W]};
    assign k_sum     = {1'b0, ca_reg[CNT_W-1:0]} + {1'b0, cnt_rd[CNT_W-1:0]};
    assign acc_sum   = {10'd0, total_reg} + (COST_W+10)'(prod_reg);

    // Edge store: insertion keeps entries sorted by weight
    always_comb
    begin
        edge_we = cmd.ins_shift || cmd.ins_new;
        edge_wa = pos_reg[EDGE_AW-1:0];
        edge_wd = cmd.ins_shift ? edge_rd : {w_reg, a_reg, b_reg};
        edge_ra = cmd.ins_rd ? pos_m1[EDGE_AW-1:0] : i_reg[EDGE_AW-1:0];
    end

    // Union-find links
    always_comb
    begin
        par_we = cmd.clr_step || cmd.mul;
        par_wa = cmd.clr_step ? clr_idx_reg : rv_reg;
        par_wd = cmd.clr_step ? clr_idx_reg : ru_reg;
    end

    // Token and component counters
    always_comb
    begin
        cnt_we = cmd.clr_step || cmd.mul ||
                 (cmd.tok_upd && (tok_field < CNT_W'(TOK_MAX)));
        cnt_wa = cmd.clr_step ? clr_idx_reg : (cmd.mul ? ru_reg : a_reg);
        cnt_wd = '0;
        if (cmd.mul)
        begin
            cnt_wd = {s_reg - m_reg, k_reg - m_reg};
        end
        else if (cmd.tok_upd)
        begin
            cnt_wd = cnt_rd;
            if (op_reg == OP_SRC)
                cnt_wd[2*CNT_W-1:CNT_W] = tok_field + CNT_W'(1);
            else
                cnt_wd[CNT_W-1:0] = tok_field + CNT_W'(1);
        end
        cnt_ra = cmd.cnt_rd_ru ? ru_reg : (cmd.cnt_rd_rv ? rv_reg : a_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pos_reg     <= '0;
            i_reg       <= '0;
            drop_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            clr_idx_reg <= '0;
            op_reg      <= OP_EDGE;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + NODE_W'(1);
                count_reg   <= '0;
                drop_reg    <= 1'b0;
            end
            if (cmd.latch)
            begin
                op_reg  <= op_t'(opcode);
                pos_reg <= count_reg;
                i_reg   <= '0;
            end
            if (cmd.set_drop || (cmd.tok_upd && !(tok_field < CNT_W'(TOK_MAX))))
                drop_reg <= 1'b1;
            if (cmd.ins_shift)
                pos_reg <= pos_m1;
            if (cmd.ins_new)
                count_reg <= count_reg + ECNT_W'(1);
            if (cmd.edge_lat)
                phase_reg <= 1'b0;
            if (cmd.set_ru)
                phase_reg <= 1'b1;
            if (cmd.next_edge)
                i_reg <= i_reg + ECNT_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            a_reg <= vertex_a;
            b_reg <= vertex_b;
            w_reg <= weight;
            if (op_t'(opcode) == OP_RUN)
                total_reg <= '0;
        end
        if (cmd.edge_lat)
        begin
            ew_reg <= edge_rd[EDGE_W-1:2*NODE_W];
            eu_reg <= edge_rd[2*NODE_W-1:NODE_W];
            ev_reg <= edge_rd[NODE_W-1:0];
            x_reg  <= edge_rd[2*NODE_W-1:NODE_W];
        end
        if (cmd.find_step)
            x_reg <= par_rd;
        if (cmd.set_ru)
        begin
            ru_reg <= x_reg;
            x_reg  <= ev_reg;
        end
        if (cmd.set_rv)
            rv_reg <= x_reg;
        if (cmd.cnt_rd_rv)
            ca_reg <= cnt_rd;
        if (cmd.sum)
        begin
            s_reg <= s_sum[CNT_W-1:0];
            k_reg <= k_sum[CNT_W-1:0];
            m_reg <= (s_sum >= k_sum) ? k_sum[CNT_W-1:0] : s_sum[CNT_W-1:0];
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(ew_reg) * PROD_W'(m_reg);
        if (cmd.acc)
        begin
            if (acc_sum[COST_W+9:COST_W] != '0)
                total_reg <= '1;
            else
                total_reg <= acc_sum[COST_W-1:0];
        end
    end

    // Status
    always_comb
    begin
        sts.op        = op_reg;
        sts.edge_full = (count_reg == ECNT_W'(MAX_EDGES));
        sts.pos_zero  = (pos_reg == '0);
        sts.shift_gt  = (edge_rd[EDGE_W-1:2*NODE_W] > w_reg);
        sts.run_done  = (i_reg == count_reg);
        sts.is_root   = (par_rd == x_reg);
        sts.phase     = phase_reg;
        sts.same_root = (x_reg == ru_reg);
        sts.clr_last  = (clr_idx_reg == NODE_W'(NODES - 1));
    end

    assign total_cost = total_reg;
    assign overflow   = drop_reg;
endmodule

### src/kruskal_bottleneck_pair_cost.sv
// Top level: bottleneck pair cost over a Kruskal spanning forest.
//
// Input channel in_ch takes commands: load edge, add source token, add sink
// token, run. Edges are kept sorted by weight as they are loaded: each entry
// shifted costs one read and one write of the edge RAM; a load on a full
// store is dropped. A token add is a read-modify-write of the counter RAM. No
// item is taken while a command is in progress.
// A run walks the sorted edges, following links in the union-find RAM to
// both roots, and a merge adds counter reads, matching, a 32x17 multiply and
// a saturating add. The run then offers one result on out_ch (total cost,
// drop flag) and holds it until taken; a stalled receiver simply keeps the
// block waiting. After delivery, and after reset, a clearing pass over all
// 256 vertices resets links and token counters; no input item is accepted
// during it. Edge count and drop flag return to zero.
`timescale 1ns / 1ps
module kruskal_bottleneck_pair_cost (
    input  logic       clk,
    input  logic       rst_n,
    kbpc_in_if.sink    in_ch,
    kbpc_out_if.source out_ch
);
    import kbpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kbpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .cmd(cmd)
    );

    kbpc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .opcode(in_ch.opcode), .vertex_a(in_ch.vertex_a),
        .vertex_b(in_ch.vertex_b), .weight(in_ch.weight),
        .total_cost(out_ch.total_cost), .overflow(out_ch.overflow)
    );

`ifndef NO_ASSERTIONS
    // Never ready for a command while a result is pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");

    // Clearing pass follows every delivered result
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> !in_ch.ready)
        else $error("input accepted during clearing");

    // Load commands give no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.opcode != OP_RUN) |=> ##1 !out_ch.valid)
        else $error("result after load command");
`endif
endmodule

### tb/kruskal_bottleneck_pair_cost_tb.sv
// Testbench: checks the bottleneck pair cost block against an internal Kruskal predictor.
`timescale 1ns / 1ps
module kruskal_bottleneck_pair_cost_tb;
    import kbpc_pkg::*;

    localparam longint unsigned COST_SAT  = 64'hFF_FFFF_FFFF;
    localparam int              CYCLE_CAP = 6000000;

    typedef struct packed {
        op_t               op;
        logic [7:0]        a;
        logic [7:0]        b;
        logic [31:0]       w;
        logic              known;
        logic [COST_W-1:0] cost;
        logic              ovf;
    } row_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              ovf;
    } pair_result_t;

    // directed items; expected values given only where they are obvious
    localparam int N_DIR = 23;
    localparam row_t DIRECTED [N_DIR] = '{
        '{OP_RUN,  8'd0,   8'd0,   32'd0,          1'b1, 40'd0,          1'b0},
        '{OP_SRC,  8'd255, 8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SNK,  8'd0,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd0,   8'd255, 32'hFFFF_FFFF,  1'b0, 40'd0,          1'b0},
        '{OP_RUN,  8'd0,   8'd0,   32'd0,          1'b1, 40'hFF_FFFF_FF, 1'b0},
        '{OP_EDGE, 8'd3,   8'd3,   32'd100,        1'b0, 40'd0,          1'b0},
        '{OP_SRC,  8'd3,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SNK,  8'd3,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_RUN,  8'd0,   8'd0,   32'd0,          1'b1, 40'd0,          1'b0},
        '{OP_EDGE, 8'd1,   8'd2,   32'd5,          1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd2,   8'd1,   32'd5,          1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd0,   8'd1,   32'd5,          1'b0, 40'd0,          1'b0},
        '{OP_SRC,  8'd0,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SNK,  8'd2,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SRC,  8'd1,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SNK,  8'd0,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd2,   8'd3,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_RUN,  8'd0,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd170, 8'd85,  32'hAAAA_AAAA,  1'b0, 40'd0,          1'b0},
        '{OP_EDGE, 8'd85,  8'd170, 32'h5555_5555,  1'b0, 40'd0,          1'b0},
        '{OP_SRC,  8'd170, 8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_SNK,  8'd85,  8'd0,   32'd0,          1'b0, 40'd0,          1'b0},
        '{OP_RUN,  8'd0,   8'd0,   32'd0,          1'b0, 40'd0,          1'b0}
    };

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   errors = 0;
    bit   no_idle;

    kbpc_in_if  in_ch ();
    kbpc_out_if out_ch ();

    kruskal_bottleneck_pair_cost dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // predictor state: loaded edges as {weight, a, b} keys, token stores, drop flag
    logic [47:0]  edge_keys [$];
    logic [8:0]   src_tokens [NODES];
    logic [8:0]   snk_tokens [NODES];
    logic         dropped;
    pair_result_t pending_results [$];

    always #5 clk = ~clk;

    task automatic clear_job();
        edge_keys.delete();
        foreach (src_tokens[i])
        begin
            src_tokens[i] = '0;
            snk_tokens[i] = '0;
        end
        dropped = 1'b0;
    endtask

    // sort edges, union-find over them, match tokens on each merge
    function automatic pair_result_t pair_cost();
        logic [47:0]     order [$];
        int unsigned     link [NODES];
        longint unsigned comp_src [NODES];
        longint unsigned comp_snk [NODES];
        longint unsigned total;
        longint unsigned s;
        longint unsigned k;
        longint unsigned m;
        longint unsigned add;
        int unsigned     ru;
        int unsigned     rv;
        pair_result_t    r;
        order = edge_keys;
        order.sort();
        total = 0;
        for (int i = 0; i < NODES; i++)
        begin
            link[i]     = i;
            comp_src[i] = 64'(src_tokens[i]);
            comp_snk[i] = 64'(snk_tokens[i]);
        end
        foreach (order[i])
        begin
            ru = 32'(order[i][15:8]);
            rv = 32'(order[i][7:0]);
            while (link[ru] != ru) ru = link[ru];
            while (link[rv] != rv) rv = link[rv];
            if (ru != rv)
            begin
                s   = comp_src[ru] + comp_src[rv];
                k   = comp_snk[ru] + comp_snk[rv];
                m   = (s < k) ? s : k;
                add = 64'(order[i][47:16]) * m;
                total = (add > COST_SAT - total) ? COST_SAT : total + add;
                link[rv]     = ru;
                comp_src[ru] = s - m;
                comp_snk[ru] = k - m;
            end
        end
        r.cost = total[COST_W-1:0];
        r.ovf  = dropped;
        return r;
    endfunction

    // apply one accepted item to the predictor; runs return their result
    function automatic pair_result_t apply_item(op_t op, logic [7:0] a, logic [7:0] b,
                                                logic [31:0] w);
        pair_result_t r;
        r = '0;
        case (op)
            OP_EDGE:
                if (edge_keys.size() >= MAX_EDGES) dropped = 1'b1;
                else edge_keys.insert(edge_keys.size(), {w, a, b});
            OP_SRC:
                if (src_tokens[a] >= TOK_MAX) dropped = 1'b1;
                else src_tokens[a]++;
            OP_SNK:
                if (snk_tokens[a] >= TOK_MAX) dropped = 1'b1;
                else snk_tokens[a]++;
            default:
                r = pair_cost();
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 45) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // drive one item and wait for its handshake; a typed expectation overrides the predictor
    task automatic send_item(op_t op, logic [7:0] a, logic [7:0] b, logic [31:0] w,
                             bit known = 0, logic [COST_W-1:0] cost = '0,
                             logic ovf = 1'b0);
        int           gap;
        pair_result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= op;
        in_ch.vertex_a <= a;
        in_ch.vertex_b <= b;
        in_ch.weight   <= w;
        do @(posedge clk); while (!in_ch.ready);
        r = apply_item(op, a, b, w);
        if (op == OP_RUN)
        begin
            // a run empties the edge store, token stores and drop flag
            clear_job();
            if (known)
            begin
                r.cost = cost;
                r.ovf  = ovf;
            end
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(4))
            0: return 32'hFFFF_FFFF;
            1: return $urandom_range(3);
            2: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_vertex(int span);
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(span - 1));
    endfunction

    // one random job: a handful of edges and tokens in random order, then a run
    task automatic random_job();
        int span;
        int n;
        op_t op;
        span = $urandom_range(1, 3) == 1 ? 4 : 16;
        n    = $urandom_range(24, 2);
        no_idle = ($urandom_range(4) == 0);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(2))
                0: op = OP_EDGE;
                1: op = OP_SRC;
                default: op = OP_SNK;
            endcase
            send_item(op, rand_vertex(span), rand_vertex(span), rand_weight());
        end
        send_item(OP_RUN, 8'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic note_mismatch(string what, logic [COST_W-1:0] got,
                                 logic [COST_W-1:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // result side: random stalls, compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        int roll;
        pair_result_t want;
        roll = $urandom_range(99);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected result", out_ch.total_cost, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.total_cost !== want.cost)
                    note_mismatch("total_cost", out_ch.total_cost, want.cost);
                if (out_ch.overflow !== want.ovf)
                    note_mismatch("overflow", COST_W'(out_ch.overflow), COST_W'(want.ovf));
            end
        end
        out_ch.ready <= no_idle || roll < 70 || (roll >= 97 && $urandom_range(1));
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        no_idle        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.opcode   = OP_EDGE;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        in_ch.weight   = '0;
        clear_job();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].w,
                      DIRECTED[i].known, DIRECTED[i].cost, DIRECTED[i].ovf);

        // token counter full on one vertex
        no_idle = 1'b1;
        for (int i = 0; i < 513; i++) send_item(OP_SRC, 8'd7, 8'd0, 32'd0);
        send_item(OP_SNK, 8'd9, 8'd0, 32'd0);
        send_item(OP_EDGE, 8'd9, 8'd7, 32'd3);
        send_item(OP_RUN, 8'd0, 8'd0, 32'd0, 1'b1, 40'd3, 1'b1);

        // saturating total
        for (int i = 0; i < 300; i++)
        begin
            send_item(OP_SRC, 8'd0, 8'd0, 32'd0);
            send_item(OP_SNK, 8'd1, 8'd0, 32'd0);
        end
        send_item(OP_EDGE, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_item(OP_RUN, 8'd0, 8'd0, 32'd0, 1'b1, COST_SAT[COST_W-1:0], 1'b0);

        // edge store full: ascending weights keep each insertion short
        no_idle = 1'b0;
        for (int i = 0; i < 40; i++)
            send_item($urandom_range(1) ? OP_SRC : OP_SNK, 8'($urandom), 8'd0, 32'd0);
        for (int i = 0; i <= MAX_EDGES; i++)
        begin
            no_idle = (i > 8 && i < MAX_EDGES - 8);
            send_item(OP_EDGE, 8'($urandom), 8'($urandom),
                      32'(i * 4) + 32'($urandom_range(3)));
        end
        send_item(OP_RUN, 8'd0, 8'd0, 32'd0);

        // random jobs
        for (int i = 0; i < 45; i++) random_job();
        no_idle     = 1'b0;
        in_ch.valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
src/kbpc_pkg.sv
src/kbpc_in_if.sv
src/kbpc_out_if.sv
src/kbpc_ram.sv
src/kbpc_ctrl.sv
src/kbpc_dp.sv
src/kruskal_bottleneck_pair_cost.sv
tb/kruskal_bottleneck_pair_cost_tb.sv
